// File: rtl/core/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // Width of one output channel; 65535 is full intensity at 16 bits.
  localparam int unsigned OUT_BITS = 16;

  localparam int unsigned HUE_W = 9;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned REM_W = 6;
  localparam int unsigned FAC_W = 13;

  // Channel numerators run up to 600000 and need 20 bits.
  localparam int unsigned NUM_W = 20;
  localparam int unsigned X_W   = NUM_W + OUT_BITS;

  localparam logic [HUE_W-1:0] HUE_TURN   = 9'd360;
  localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
  localparam logic [REM_W-1:0] SECTOR_DEG = 6'd60;
  localparam logic [FAC_W-1:0] UNIT_NUM   = 13'd6000;
  localparam logic [NUM_W-1:0] DENOM      = 20'd600000;
  localparam logic [NUM_W-1:0] HALF_DENOM = 20'd300000;

  // 600000 is 64 * 9375: the power of two is dropped as low bits and the odd
  // part is divided by a rounded-up reciprocal.
  localparam int unsigned DEN_SHIFT = 6;
  localparam int unsigned DEN_ODD   = 9375;
  localparam int unsigned Z_W       = X_W - DEN_SHIFT;
  // 2^14 is above 9375, so the reciprocal error times any Z_W-bit dividend
  // stays below 2^RCP_SHIFT and the quotient is exact. 9375 is above 2^13,
  // so the reciprocal fits in RCP_SHIFT - 13 bits.
  localparam int unsigned RCP_SHIFT = Z_W + 14;
  localparam int unsigned RCP_W     = RCP_SHIFT - 13;
  localparam longint unsigned RCP_VAL =
      ((64'd1 << RCP_SHIFT) + 64'(DEN_ODD) - 64'd1) / 64'(DEN_ODD);
  localparam logic [RCP_W-1:0] RCP_MUL = RCP_VAL[RCP_W-1:0];

  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  typedef enum logic [2:0] {
    SECT_R_TO_Y = 3'd0,
    SECT_Y_TO_G = 3'd1,
    SECT_G_TO_C = 3'd2,
    SECT_C_TO_B = 3'd3,
    SECT_B_TO_M = 3'd4,
    SECT_M_TO_R = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HUE_W-1:0] hue_degrees;
    logic [PCT_W-1:0] saturation_pct;
    logic [PCT_W-1:0] brightness_pct;
  } in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] red_level;
    logic [OUT_BITS-1:0] green_level;
    logic [OUT_BITS-1:0] blue_level;
  } out_t;

  typedef logic [2:0][NUM_W-1:0]    num_trio_t;
  typedef logic [2:0][OUT_BITS-1:0] lvl_trio_t;

  // Pipeline control shared between the top level and the scaler.
  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

endpackage

// File: rtl/core/hsv2rgb_scale.sv
// Scales three numerators N to round-half-up(N * FULL / 600000).
// The first stage forms N * FULL + 300000 and drops the six low bits that
// belong to the factor 64 of 600000. The second stage multiplies by the
// reciprocal of 9375 in two halves, and the third adds the halves and keeps
// the quotient bits as the registered level.
module hsv2rgb_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hsv2rgb_pkg::pipe_ctl_t ctl_i,
  input  hsv2rgb_pkg::num_trio_t num_i,
  output logic                   valid_o,
  output hsv2rgb_pkg::lvl_trio_t level_o
);

  localparam int unsigned NB = hsv2rgb_pkg::OUT_BITS;
  localparam int unsigned XW = hsv2rgb_pkg::X_W;
  localparam int unsigned ZW = hsv2rgb_pkg::Z_W;
  localparam int unsigned MW = hsv2rgb_pkg::RCP_W;
  localparam int unsigned LW = MW / 2;
  localparam int unsigned HW = MW - LW;
  localparam int unsigned PW = ZW + MW;
  localparam int unsigned SH = hsv2rgb_pkg::RCP_SHIFT;

  logic [2:0]    vld_q;
  logic [MW-1:0] rcp;

  assign rcp = hsv2rgb_pkg::RCP_MUL;

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.adv) begin
      vld_q <= {vld_q[1:0], ctl_i.vld};
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [XW-1:0]    x_d;
    logic [ZW-1:0]    z_q;
    logic [ZW+LW-1:0] pl_q;
    logic [ZW+HW-1:0] ph_q;
    logic [PW-1:0]    prod;
    logic [NB-1:0]    level_q;

    // N * (2^B - 1) + D/2, done as a shift and a subtract.
    assign x_d = {num_i[c], {NB{1'b0}}} - {{NB{1'b0}}, num_i[c]}
               + {{NB{1'b0}}, hsv2rgb_pkg::HALF_DENOM};

    // Full product Z * M; the quotient sits at bit SH and up.
    assign prod = {{HW{1'b0}}, pl_q} + {ph_q, {LW{1'b0}}};

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        z_q     <= x_d[XW-1:hsv2rgb_pkg::DEN_SHIFT];
        pl_q    <= {{LW{1'b0}}, z_q} * {{ZW{1'b0}}, rcp[LW-1:0]};
        ph_q    <= {{HW{1'b0}}, z_q} * {{ZW{1'b0}}, rcp[MW-1:LW]};
        level_q <= prod[SH+NB-1:SH];
      end
    end

    assign level_o[c] = level_q;
  end

  assign valid_o = vld_q[2];

endmodule

// File: rtl/core/hsv_to_rgb_converter_core.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  in_data_i  (hue, saturation, brightness)
// out       output     out_valid_o / out_stall_i out_data_o (red, green, blue levels)
//
// One request is accepted every cycle unless a stalled output freezes the pipeline;
// two stages form the numerators and three stages scale them with a shift and a
// reciprocal multiply.
// Reset clears only the valid bits of the pipeline; payload registers are left as they are.
// While the output holds a result that is stalled the whole pipeline freezes, and the
// input stalls with it, so nothing is lost or repeated.
module hsv_to_rgb_converter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hsv2rgb_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hsv2rgb_pkg::out_t  out_data_o
);

  localparam int unsigned HW = hsv2rgb_pkg::HUE_W;
  localparam int unsigned PW = hsv2rgb_pkg::PCT_W;
  localparam int unsigned RW = hsv2rgb_pkg::REM_W;
  localparam int unsigned FW = hsv2rgb_pkg::FAC_W;
  localparam int unsigned NW = hsv2rgb_pkg::NUM_W;

  // The pipeline moves as one whenever the output register can be refilled.
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------------------------------------------------------------
  // Stage 1: clamp the inputs, find the hue sector and its remainder, and
  // form the saturation factors 6000 - S*60, 6000 - S*r, 6000 - S*(60-r).
  // ---------------------------------------------------------------------
  logic [HW-1:0]        hue_c;
  logic [PW-1:0]        sat_c;
  logic [PW-1:0]        val_c;
  hsv2rgb_pkg::sector_e sect_d;
  logic [HW-1:0]        sect_base;
  logic [HW-1:0]        rem_full;
  logic [RW-1:0]        rem_d;
  logic [RW-1:0]        rem_inv;
  logic [FW-1:0]        p_fac_d;
  logic [FW-1:0]        q_fac_d;
  logic [FW-1:0]        t_fac_d;

  assign hue_c = (in_data_i.hue_degrees >= hsv2rgb_pkg::HUE_TURN) ? '0
               : in_data_i.hue_degrees;
  assign sat_c = (in_data_i.saturation_pct > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX
               : in_data_i.saturation_pct;
  assign val_c = (in_data_i.brightness_pct > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX
               : in_data_i.brightness_pct;

  // Hue is below 360 here, so five threshold compares pick the sector.
  always_comb begin
    if (hue_c >= 9'd300) begin
      sect_d    = hsv2rgb_pkg::SECT_M_TO_R;
      sect_base = 9'd300;
    end else if (hue_c >= 9'd240) begin
      sect_d    = hsv2rgb_pkg::SECT_B_TO_M;
      sect_base = 9'd240;
    end else if (hue_c >= 9'd180) begin
      sect_d    = hsv2rgb_pkg::SECT_C_TO_B;
      sect_base = 9'd180;
    end else if (hue_c >= 9'd120) begin
      sect_d    = hsv2rgb_pkg::SECT_G_TO_C;
      sect_base = 9'd120;
    end else if (hue_c >= 9'd60) begin
      sect_d    = hsv2rgb_pkg::SECT_Y_TO_G;
      sect_base = 9'd60;
    end else begin
      sect_d    = hsv2rgb_pkg::SECT_R_TO_Y;
      sect_base = 9'd0;
    end
  end

  assign rem_full = hue_c - sect_base;
  assign rem_d    = rem_full[RW-1:0];
  assign rem_inv  = hsv2rgb_pkg::SECTOR_DEG - rem_d;

  assign p_fac_d = hsv2rgb_pkg::UNIT_NUM
                 - ({{(FW-PW){1'b0}}, sat_c} * {{(FW-RW){1'b0}}, hsv2rgb_pkg::SECTOR_DEG});
  assign q_fac_d = hsv2rgb_pkg::UNIT_NUM
                 - ({{(FW-PW){1'b0}}, sat_c} * {{(FW-RW){1'b0}}, rem_d});
  assign t_fac_d = hsv2rgb_pkg::UNIT_NUM
                 - ({{(FW-PW){1'b0}}, sat_c} * {{(FW-RW){1'b0}}, rem_inv});

  logic                 s1_vld_q;
  hsv2rgb_pkg::sector_e s1_sect_q;
  logic [PW-1:0]        s1_val_q;
  logic [FW-1:0]        s1_p_q;
  logic [FW-1:0]        s1_q_q;
  logic [FW-1:0]        s1_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sect_q <= sect_d;
      s1_val_q  <= val_c;
      s1_p_q    <= p_fac_d;
      s1_q_q    <= q_fac_d;
      s1_t_q    <= t_fac_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: multiply each factor by the brightness to get the numerators
  // over 600000, then route v, p, q, t to red, green and blue by sector.
  // ---------------------------------------------------------------------
  logic [NW-1:0]          nv;
  logic [NW-1:0]          np;
  logic [NW-1:0]          nq;
  logic [NW-1:0]          nt;
  hsv2rgb_pkg::num_trio_t num_d;

  assign nv = {{(NW-PW){1'b0}}, s1_val_q} * {{(NW-FW){1'b0}}, hsv2rgb_pkg::UNIT_NUM};
  assign np = {{(NW-PW){1'b0}}, s1_val_q} * {{(NW-FW){1'b0}}, s1_p_q};
  assign nq = {{(NW-PW){1'b0}}, s1_val_q} * {{(NW-FW){1'b0}}, s1_q_q};
  assign nt = {{(NW-PW){1'b0}}, s1_val_q} * {{(NW-FW){1'b0}}, s1_t_q};

  always_comb begin
    case (s1_sect_q)
      hsv2rgb_pkg::SECT_R_TO_Y: begin
        num_d[hsv2rgb_pkg::CH_RED]   = nv;
        num_d[hsv2rgb_pkg::CH_GREEN] = nt;
        num_d[hsv2rgb_pkg::CH_BLUE]  = np;
      end
      hsv2rgb_pkg::SECT_Y_TO_G: begin
        num_d[hsv2rgb_pkg::CH_RED]   = nq;
        num_d[hsv2rgb_pkg::CH_GREEN] = nv;
        num_d[hsv2rgb_pkg::CH_BLUE]  = np;
      end
      hsv2rgb_pkg::SECT_G_TO_C: begin
        num_d[hsv2rgb_pkg::CH_RED]   = np;
        num_d[hsv2rgb_pkg::CH_GREEN] = nv;
        num_d[hsv2rgb_pkg::CH_BLUE]  = nt;
      end
      hsv2rgb_pkg::SECT_C_TO_B: begin
        num_d[hsv2rgb_pkg::CH_RED]   = np;
        num_d[hsv2rgb_pkg::CH_GREEN] = nq;
        num_d[hsv2rgb_pkg::CH_BLUE]  = nv;
      end
      hsv2rgb_pkg::SECT_B_TO_M: begin
        num_d[hsv2rgb_pkg::CH_RED]   = nt;
        num_d[hsv2rgb_pkg::CH_GREEN] = np;
        num_d[hsv2rgb_pkg::CH_BLUE]  = nv;
      end
      default: begin
        num_d[hsv2rgb_pkg::CH_RED]   = nv;
        num_d[hsv2rgb_pkg::CH_GREEN] = np;
        num_d[hsv2rgb_pkg::CH_BLUE]  = nq;
      end
    endcase
  end

  logic                   s2_vld_q;
  hsv2rgb_pkg::num_trio_t s2_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_num_q <= num_d;
    end
  end

  // ---------------------------------------------------------------------
  // Remaining stages: scale each numerator to the output range with
  // round-half-up. The last scaler stage is the output register.
  // ---------------------------------------------------------------------
  hsv2rgb_pkg::pipe_ctl_t scale_ctl;
  hsv2rgb_pkg::lvl_trio_t level;

  assign scale_ctl.adv = adv;
  assign scale_ctl.vld = s2_vld_q;

  hsv2rgb_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scale_ctl),
    .num_i   (s2_num_q),
    .valid_o (out_valid_o),
    .level_o (level)
  );

  assign out_data_o.red_level   = level[hsv2rgb_pkg::CH_RED];
  assign out_data_o.green_level = level[hsv2rgb_pkg::CH_GREEN];
  assign out_data_o.blue_level  = level[hsv2rgb_pkg::CH_BLUE];

endmodule

// File: bench/tb_top.sv
module tb_top;

  localparam int unsigned LVL_W = hsv2rgb_pkg::OUT_BITS;

  // The block answers each request after its pipeline stages. A drain wait
  // after the last result catches any stray extra output.
  localparam int unsigned LATENCY        = 5;
  localparam int unsigned DRAIN_CYCLES   = 2 * LATENCY + 2;
  localparam int unsigned RANDOM_REQS    = 1550;
  // The worst case comes from both sides idling at random,
  // plus the long receiver hold-off. This limit is many times that.
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned IDLE_PCT       = 30;
  localparam int unsigned HOLDOFF_CYCLES = 150;
  localparam int unsigned HOLDOFF_AFTER  = 250;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  hsv2rgb_pkg::in_t  in_data  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  hsv2rgb_pkg::out_t out_data;

  // Requests waiting to be offered, and the colors the block owes us, oldest first.
  hsv2rgb_pkg::in_t  pending_colors[$];
  hsv2rgb_pkg::out_t owed_levels[$];

  int unsigned sent_cnt    = 0;
  int unsigned results_cnt = 0;
  int unsigned fail_cnt    = 0;
  int unsigned cycle_cnt   = 0;

  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;

  hsv_to_rgb_converter_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Scales an exact numerator over 600000 to a duty level, rounding half up.
  function automatic logic [LVL_W-1:0] numer_to_level(longint unsigned numer);
    longint unsigned full;
    longint unsigned lvl;
    full = (64'd1 << LVL_W) - 64'd1;
    lvl  = (numer * full + 64'(hsv2rgb_pkg::HALF_DENOM)) / 64'(hsv2rgb_pkg::DENOM);
    return lvl[LVL_W-1:0];
  endfunction

  // Expected RGB levels for one HSV request. Out-of-range inputs are clamped,
  // and hue 360 or above is treated as hue 0.
  function automatic hsv2rgb_pkg::out_t hsv_to_levels(hsv2rgb_pkg::in_t req);
    longint unsigned      hue, sat, bri, rem, sect_num;
    longint unsigned      v_num, p_num, q_num, t_num;
    logic [LVL_W-1:0]     v_lv, p_lv, q_lv, t_lv;
    hsv2rgb_pkg::sector_e sect;
    hsv2rgb_pkg::out_t    lv;
    hue = 64'(req.hue_degrees);
    sat = 64'(req.saturation_pct);
    bri = 64'(req.brightness_pct);
    if (hue >= 64'(hsv2rgb_pkg::HUE_TURN)) hue = 64'd0;
    if (sat > 64'(hsv2rgb_pkg::PCT_MAX)) sat = 64'(hsv2rgb_pkg::PCT_MAX);
    if (bri > 64'(hsv2rgb_pkg::PCT_MAX)) bri = 64'(hsv2rgb_pkg::PCT_MAX);
    sect_num = hue / 64'(hsv2rgb_pkg::SECTOR_DEG);
    sect     = hsv2rgb_pkg::sector_e'(sect_num[2:0]);
    rem      = hue % 64'(hsv2rgb_pkg::SECTOR_DEG);

    // v is the brightness itself; p, q and t are the usual shaded values.
    v_num = bri * 64'(hsv2rgb_pkg::UNIT_NUM);
    p_num = bri * (64'(hsv2rgb_pkg::PCT_MAX) - sat) * 64'(hsv2rgb_pkg::SECTOR_DEG);
    q_num = bri * (64'(hsv2rgb_pkg::UNIT_NUM) - sat * rem);
    t_num = bri * (64'(hsv2rgb_pkg::UNIT_NUM)
                   - sat * (64'(hsv2rgb_pkg::SECTOR_DEG) - rem));

    v_lv = numer_to_level(v_num);
    p_lv = numer_to_level(p_num);
    q_lv = numer_to_level(q_num);
    t_lv = numer_to_level(t_num);

    case (sect)
      hsv2rgb_pkg::SECT_R_TO_Y: lv = {v_lv, t_lv, p_lv};
      hsv2rgb_pkg::SECT_Y_TO_G: lv = {q_lv, v_lv, p_lv};
      hsv2rgb_pkg::SECT_G_TO_C: lv = {p_lv, v_lv, t_lv};
      hsv2rgb_pkg::SECT_C_TO_B: lv = {p_lv, q_lv, v_lv};
      hsv2rgb_pkg::SECT_B_TO_M: lv = {t_lv, p_lv, v_lv};
      default:                  lv = {v_lv, p_lv, q_lv};
    endcase
    return lv;
  endfunction

  task automatic queue_color(int unsigned hue, int unsigned sat, int unsigned bri);
    hsv2rgb_pkg::in_t req;
    req.hue_degrees    = hue[hsv2rgb_pkg::HUE_W-1:0];
    req.saturation_pct = sat[hsv2rgb_pkg::PCT_W-1:0];
    req.brightness_pct = bri[hsv2rgb_pkg::PCT_W-1:0];
    pending_colors.push_back(req);
  endtask

  // Percentages are mostly in range, with both edges and the clamped region
  // above 100 hit often enough to matter.
  function automatic int unsigned pick_pct();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return 0;
    if (roll < 10) return 32'(hsv2rgb_pkg::PCT_MAX);
    if (roll < 20) return $urandom_range(127, 101);
    return $urandom_range(100);
  endfunction

  function automatic int unsigned pick_hue();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return 32'(hsv2rgb_pkg::HUE_TURN);
    if (roll < 10) return $urandom_range(511, 361);
    if (roll < 16) return $urandom_range(5) * 32'(hsv2rgb_pkg::SECTOR_DEG);
    return $urandom_range(359);
  endfunction

  task automatic check_channel(string chan, logic [LVL_W-1:0] want,
                               logic [LVL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
      fail_cnt++;
    end
  endtask

  // Driver. A request is taken at an edge where valid is high and stall is low.
  // An offered request is held until taken; only then may the next one appear
  // or valid drop for an idle cycle. The sender is idle-free for a stretch of
  // requests in the middle of the run.
  always @(posedge clk_i or negedge rst_ni) begin : driver_proc
    bit req_taken;
    bit sender_calm;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      req_taken   = in_valid && !in_stall;
      sender_calm = (sent_cnt >= 700) && (sent_cnt < 1000);
      if (req_taken) begin
        owed_levels.push_back(hsv_to_levels(in_data));
        sent_cnt++;
      end
      if (in_valid && !req_taken) begin
        // Stalled: keep valid and payload as they are.
      end else if (pending_colors.size() > 0 &&
                   (sender_calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= pending_colors.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver. Each taken result is checked against the oldest
  // owed color. The receiver stalls at random, runs stall-free for a stretch,
  // and once holds off for a long time so the pipeline fills and the block
  // has to stall its input while the driver keeps offering.
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    hsv2rgb_pkg::out_t want;
    bit                recv_calm;
    bit                stall_next;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_levels.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_cnt++;
        end else begin
          want = owed_levels.pop_front();
          check_channel("red_level", want.red_level, out_data.red_level);
          check_channel("green_level", want.green_level, out_data.green_level);
          check_channel("blue_level", want.blue_level, out_data.blue_level);
        end
        results_cnt++;
      end

      recv_calm = (results_cnt >= 680) && (results_cnt < 1000);
      if (holdoff_left > 0) begin
        holdoff_left--;
        stall_next = 1'b1;
      end else if (!holdoff_done && results_cnt >= HOLDOFF_AFTER) begin
        holdoff_left = HOLDOFF_CYCLES - 1;
        holdoff_done = 1'b1;
        stall_next   = 1'b1;
      end else begin
        stall_next = !recv_calm && ($urandom_range(99) < IDLE_PCT);
      end
      out_stall <= stall_next;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    // Directed colors: each sector at full saturation, sector edges, the top
    // of the hue circle and the wrap at 360, grey, black, and clamped inputs.
    queue_color(0, 100, 100);
    queue_color(60, 100, 100);
    queue_color(120, 100, 100);
    queue_color(180, 100, 100);
    queue_color(240, 100, 100);
    queue_color(300, 100, 100);
    queue_color(59, 100, 100);
    queue_color(359, 100, 100);
    queue_color(360, 100, 100);
    queue_color(361, 50, 80);
    queue_color(511, 127, 127);
    queue_color(30, 0, 75);
    queue_color(200, 0, 100);
    queue_color(0, 0, 0);
    queue_color(150, 127, 0);
    queue_color(90, 101, 100);
    queue_color(45, 100, 101);
    queue_color(270, 64, 64);
    queue_color(330, 55, 33);
    queue_color(15, 37, 91);
    queue_color(256, 1, 1);
    queue_color(119, 99, 99);

    for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
      queue_color(pick_hue(), pick_pct(), pick_pct());
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request has gone in and every result has come out.
    while (pending_colors.size() > 0 || in_valid || owed_levels.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: hsv_to_rgb_converter_core.f
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_scale.sv
rtl/core/hsv_to_rgb_converter_core.sv
bench/tb_top.sv
